// ===== hdl/swd_host_transaction_engine_macros.svh =====
// ----------------------------------------------------------------------------
// SWD host transaction engine - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SWD_HOST_TRANSACTION_ENGINE_MACROS_SVH
`define SWD_HOST_TRANSACTION_ENGINE_MACROS_SVH

// Same-cycle implication
`define SWD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SWD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// SWD host package
// Request and result item types and the codes shared by the engine files.
// ----------------------------------------------------------------------------
package swd_pkg;

    // Default length of a line reset run, in bit periods
    localparam int unsigned LINE_RESET_BITS_DEF = 64;

    // Request function codes
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_READ   = 3'd1;
    localparam logic [2:0] FUNC_WRITE  = 3'd2;
    localparam logic [2:0] FUNC_LRESET = 3'd3;
    localparam logic [2:0] FUNC_RAW    = 3'd4;

    // Target acknowledge code for a good transfer
    localparam logic [2:0] ACK_OK = 3'b001;

    // Completion status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FAULT  = 2'd1;
    localparam logic [1:0] STAT_PARITY = 2'd2;

    // Largest raw run
    localparam logic [5:0] RAW_MAX = 6'd32;

    // One input item: one bit period
    typedef struct packed {
        logic [2:0]  func;
        logic        is_ap;
        logic [1:0]  reg_addr;
        logic [31:0] wdata;
        logic        ignore_ack;
        logic [5:0]  raw_count;
        logic        dio_in;
    } t_req;

    // One result item
    typedef struct packed {
        logic        dio_out;
        logic        dio_drive;
        logic        clk_pulse;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  ack_bits;
        logic [1:0]  status;
        logic [31:0] read_data;
    } t_res;

endpackage

// ===== hdl/swd_engine.sv =====
// ----------------------------------------------------------------------------
// SWD engine core
// Transaction state and the per-bit-period step: header, turnaround, ACK,
// data and parity phases, line reset and raw runs.
// ----------------------------------------------------------------------------
module swd_engine #(
    parameter int unsigned LINE_RESET_BITS = swd_pkg::LINE_RESET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  swd_pkg::t_req i_req,
    output swd_pkg::t_res o_res
);

    localparam int unsigned     CW          = $clog2(LINE_RESET_BITS + 1);
    localparam logic [CW-1:0]   LRESET_LAST = CW'(LINE_RESET_BITS);
    localparam logic [CW-1:0]   HDR_LAST    = CW'(8);
    localparam logic [CW-1:0]   ACK_LAST    = CW'(3);
    localparam logic [CW-1:0]   DATA_LAST   = CW'(32);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_HDR      = 4'd1,
        PH_TURN_IN  = 4'd2,
        PH_ACK      = 4'd3,
        PH_RDATA    = 4'd4,
        PH_RPAR     = 4'd5,
        PH_TURN_OUT = 4'd6,
        PH_WDATA    = 4'd7,
        PH_WPAR     = 4'd8,
        PH_LRESET   = 4'd9,
        PH_RAW      = 4'd10
    } t_phase;

    t_phase        r_phase, n_phase, e_phase;
    logic [CW-1:0] r_cnt, n_cnt, e_cnt, w_cnt_inc;
    logic [31:0]   r_sw, n_sw, e_sw;
    logic [7:0]    r_hb, n_hb, e_hb;
    logic          r_par, n_par, e_par;
    logic [2:0]    r_ack, n_ack, e_ack;
    logic          r_rd, n_rd, e_rd;
    logic          r_skip, n_skip, e_skip;
    logic [5:0]    w_rcnt;
    logic          w_rnw;
    logic          w_hpar;

    // Start a request when idle, then run one bit period of the current phase
    always_comb begin
        e_phase = r_phase;
        e_cnt   = r_cnt;
        e_sw    = r_sw;
        e_hb    = r_hb;
        e_par   = r_par;
        e_ack   = r_ack;
        e_rd    = r_rd;
        e_skip  = r_skip;

        o_res           = '0;
        o_res.dio_drive = 1'b1;
        o_res.status    = swd_pkg::STAT_OK;

        w_rcnt = (i_req.raw_count > swd_pkg::RAW_MAX) ? swd_pkg::RAW_MAX : i_req.raw_count;
        w_rnw  = (i_req.func == swd_pkg::FUNC_READ);
        w_hpar = i_req.is_ap ^ w_rnw ^ i_req.reg_addr[0] ^ i_req.reg_addr[1];

        // Take a new request only while idle
        if (r_phase == PH_IDLE) begin
            unique case (i_req.func)
                swd_pkg::FUNC_READ, swd_pkg::FUNC_WRITE: begin
                    // park, stop, parity, A3, A2, RnW, APnDP, start
                    e_hb    = {1'b1, 1'b0, w_hpar, i_req.reg_addr[1], i_req.reg_addr[0],
                               w_rnw, i_req.is_ap, 1'b1};
                    e_rd    = w_rnw;
                    e_skip  = w_rnw ? 1'b0 : i_req.ignore_ack;
                    e_sw    = w_rnw ? '0 : i_req.wdata;
                    e_ack   = '0;
                    e_par   = 1'b0;
                    e_cnt   = '0;
                    e_phase = PH_HDR;
                end
                swd_pkg::FUNC_LRESET: begin
                    e_cnt   = '0;
                    e_phase = PH_LRESET;
                end
                swd_pkg::FUNC_RAW: begin
                    if (w_rcnt == '0) begin
                        o_res.done_res = 1'b1;
                    end else begin
                        e_hb    = {2'b00, w_rcnt};
                        e_sw    = i_req.wdata;
                        e_cnt   = '0;
                        e_phase = PH_RAW;
                    end
                end
                default: ;
            endcase
        end

        n_phase   = e_phase;
        n_cnt     = e_cnt;
        n_sw      = e_sw;
        n_hb      = e_hb;
        n_par     = e_par;
        n_ack     = e_ack;
        n_rd      = e_rd;
        n_skip    = e_skip;
        w_cnt_inc = e_cnt + 1'b1;

        unique case (e_phase)
            PH_HDR: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_out   = e_hb[e_cnt[2:0]];
                n_cnt           = w_cnt_inc;
                if (w_cnt_inc == HDR_LAST) begin
                    n_cnt   = '0;
                    n_phase = PH_TURN_IN;
                end
            end
            PH_TURN_IN: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_drive = 1'b0;
                n_cnt           = '0;
                n_phase         = PH_ACK;
            end
            PH_ACK: begin
                // Collect ACK LSB first
                o_res.clk_pulse = 1'b1;
                o_res.dio_drive = 1'b0;
                n_ack           = e_ack | (3'(i_req.dio_in) << e_cnt[1:0]);
                n_cnt           = w_cnt_inc;
                if (w_cnt_inc == ACK_LAST) begin
                    n_cnt   = '0;
                    n_par   = 1'b0;
                    n_phase = (e_rd && n_ack == swd_pkg::ACK_OK) ? PH_RDATA : PH_TURN_OUT;
                end
            end
            PH_RDATA: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_drive = 1'b0;
                n_sw            = {i_req.dio_in, e_sw[31:1]};
                n_par           = e_par ^ i_req.dio_in;
                n_cnt           = w_cnt_inc;
                if (w_cnt_inc == DATA_LAST) begin
                    n_cnt   = '0;
                    n_phase = PH_RPAR;
                end
            end
            PH_RPAR: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_drive = 1'b0;
                n_par           = e_par ^ i_req.dio_in;
                n_phase         = PH_TURN_OUT;
            end
            PH_TURN_OUT: begin
                o_res.clk_pulse = 1'b1;
                if (e_rd) begin
                    o_res.done_res = 1'b1;
                    o_res.ack_bits = e_ack;
                    if (e_ack != swd_pkg::ACK_OK) begin
                        o_res.status = swd_pkg::STAT_FAULT;
                    end else begin
                        o_res.status    = e_par ? swd_pkg::STAT_PARITY : swd_pkg::STAT_OK;
                        o_res.read_data = e_sw;
                    end
                    n_phase = PH_IDLE;
                end else if (e_ack != swd_pkg::ACK_OK && !e_skip) begin
                    o_res.done_res = 1'b1;
                    o_res.ack_bits = e_ack;
                    o_res.status   = swd_pkg::STAT_FAULT;
                    n_phase        = PH_IDLE;
                end else begin
                    n_cnt   = '0;
                    n_par   = 1'b0;
                    n_phase = PH_WDATA;
                end
            end
            PH_WDATA: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_out   = e_sw[0];
                n_par           = e_par ^ e_sw[0];
                n_sw            = {1'b0, e_sw[31:1]};
                n_cnt           = w_cnt_inc;
                if (w_cnt_inc == DATA_LAST) begin
                    n_cnt   = '0;
                    n_phase = PH_WPAR;
                end
            end
            PH_WPAR: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_out   = e_par;
                o_res.done_res  = 1'b1;
                o_res.ack_bits  = e_ack;
                n_phase         = PH_IDLE;
            end
            PH_LRESET: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_out   = 1'b1;
                n_cnt           = w_cnt_inc;
                if (w_cnt_inc == LRESET_LAST) begin
                    n_cnt          = '0;
                    o_res.done_res = 1'b1;
                    n_phase        = PH_IDLE;
                end
            end
            PH_RAW: begin
                o_res.clk_pulse = 1'b1;
                o_res.dio_out   = e_sw[0];
                n_sw            = {1'b0, e_sw[31:1]};
                n_cnt           = w_cnt_inc;
                if (w_cnt_inc == CW'(e_hb[5:0])) begin
                    n_cnt          = '0;
                    o_res.done_res = 1'b1;
                    n_phase        = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_res.busy_res = (n_phase != PH_IDLE);
    end

    // Hold transaction state; advance once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_sw    <= '0;
            r_hb    <= '0;
            r_par   <= 1'b0;
            r_ack   <= '0;
            r_rd    <= 1'b0;
            r_skip  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_sw    <= n_sw;
            r_hb    <= n_hb;
            r_par   <= n_par;
            r_ack   <= n_ack;
            r_rd    <= n_rd;
            r_skip  <= n_skip;
        end
    end

endmodule

// ===== hdl/swd_host_transaction_engine.sv =====
// An accepted input item is held in the input register; the engine step then
//   writes its result into the result register once the result stage can take it.
// Throughput: one item per cycle unless the result side stalls; the engine state advances once per item.
// A stalled result stage holds the input register, which then drops ready.
// Reset (i_rst_n low, synchronous): both stages empty, engine idle, its state cleared.
// ----------------------------------------------------------------------------
// SWD host transaction engine - top level
// Input register, engine step and result register with valid/ready on each side.
// ----------------------------------------------------------------------------
`include "swd_host_transaction_engine_macros.svh"

module swd_host_transaction_engine #(
    parameter int unsigned LINE_RESET_BITS = swd_pkg::LINE_RESET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic        i_is_ap,
    input  logic [1:0]  i_reg_addr,
    input  logic [31:0] i_wdata,
    input  logic        i_ignore_ack,
    input  logic [5:0]  i_raw_count,
    input  logic        i_dio_in,
    // result side
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_dio_out,
    output logic        o_dio_drive,
    output logic        o_clk_pulse,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [2:0]  o_ack_bits,
    output logic [1:0]  o_status,
    output logic [31:0] o_read_data
);

    logic          r_in_valid;
    swd_pkg::t_req r_in;
    logic          r_out_valid;
    swd_pkg::t_res r_out;
    swd_pkg::t_res w_res;
    logic          w_adv;
    logic          w_fields_clear;
    logic          w_idle_out;

    // Move an item through the engine when the result stage can take it
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    swd_engine #(
        .LINE_RESET_BITS (LINE_RESET_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_req   (r_in),
        .o_res   (w_res)
    );

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.func       <= i_func;
            r_in.is_ap      <= i_is_ap;
            r_in.reg_addr   <= i_reg_addr;
            r_in.wdata      <= i_wdata;
            r_in.ignore_ack <= i_ignore_ack;
            r_in.raw_count  <= i_raw_count;
            r_in.dio_in     <= i_dio_in;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dio_out   = r_out.dio_out;
    assign o_dio_drive = r_out.dio_drive;
    assign o_clk_pulse = r_out.clk_pulse;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_ack_bits  = r_out.ack_bits;
    assign o_status    = r_out.status;
    assign o_read_data = r_out.read_data;

    // Terms for the checks
    assign w_fields_clear = (o_ack_bits == 3'd0) && (o_status == swd_pkg::STAT_OK) &&
                            (o_read_data == 32'd0);
    assign w_idle_out     = o_dio_drive && !o_dio_out && !o_busy_res;

    // Checks
    `SWD_ASSERT_IMP(a_ready_when_free, !r_out_valid || i_out_ready, o_in_ready, "input stalled")
    `SWD_ASSERT_NXT(a_result_loaded, w_adv, r_out_valid, "processed item not presented")
    `SWD_ASSERT_IMP(a_quiet_fields, r_out_valid && !o_done_res, w_fields_clear, "fields without done")
    `SWD_ASSERT_IMP(a_release_low, r_out_valid && !o_dio_drive, o_clk_pulse && !o_dio_out, "bad release")
    `SWD_ASSERT_IMP(a_idle_period, r_out_valid && !o_clk_pulse, w_idle_out, "unclocked period not idle")

endmodule

// ===== bench/swd_host_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SWD host transaction engine - result checker
// Watches both item channels, steps its own copy of the engine once per
// accepted request item, queues the predicted result items and compares each
// accepted result item, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module swd_host_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_func,
    input  logic        i_is_ap,
    input  logic [1:0]  i_reg_addr,
    input  logic [31:0] i_wdata,
    input  logic        i_ignore_ack,
    input  logic [5:0]  i_raw_count,
    input  logic        i_dio_in,
    // result side
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_dio_out,
    input  logic        i_dio_drive,
    input  logic        i_clk_pulse,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [2:0]  i_ack_bits,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_read_data,
    // verdict
    output int          o_fail_count,
    output int          o_pending
);

    // Bit period phases of the engine copy
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEADER,
        ST_TURN_RX,
        ST_ACK,
        ST_RD_DATA,
        ST_RD_PARITY,
        ST_TURN_TX,
        ST_WR_DATA,
        ST_WR_PARITY,
        ST_LINE_RESET,
        ST_RAW
    } t_eng_state;

    // Engine copy
    t_eng_state  eng_phase;
    logic [6:0]  eng_count;
    logic [31:0] eng_shift;
    logic [7:0]  eng_hdr;
    logic        eng_par;
    logic [2:0]  eng_ack;
    logic        eng_read;
    logic        eng_skip_ack;

    swd_pkg::t_res expected_q[$];
    swd_pkg::t_req seen_req;
    swd_pkg::t_res want;
    int            result_idx;

    // Step the engine copy by one bit period and return its result item
    function automatic swd_pkg::t_res predict_bit_period(input swd_pkg::t_req rq);
        swd_pkg::t_res r;
        logic          rnw;
        logic [5:0]    run_len;
        r = '0;
        r.dio_drive = 1'b1;
        run_len = rq.raw_count;

        // Take a new request only when idle
        if (eng_phase == ST_IDLE) begin
            if (rq.func == swd_pkg::FUNC_READ || rq.func == swd_pkg::FUNC_WRITE) begin
                rnw = (rq.func == swd_pkg::FUNC_READ);
                // park, stop, parity, A3, A2, RnW, APnDP, start
                eng_hdr = {1'b1, 1'b0,
                           rq.is_ap ^ rnw ^ rq.reg_addr[0] ^ rq.reg_addr[1],
                           rq.reg_addr[1], rq.reg_addr[0], rnw, rq.is_ap, 1'b1};
                eng_read     = rnw;
                eng_skip_ack = rnw ? 1'b0 : rq.ignore_ack;
                eng_shift    = rnw ? 32'd0 : rq.wdata;
                eng_ack      = 3'd0;
                eng_par      = 1'b0;
                eng_count    = 7'd0;
                eng_phase    = ST_HEADER;
            end else if (rq.func == swd_pkg::FUNC_LRESET) begin
                eng_count = 7'd0;
                eng_phase = ST_LINE_RESET;
            end else if (rq.func == swd_pkg::FUNC_RAW) begin
                if (run_len > swd_pkg::RAW_MAX) begin
                    run_len = swd_pkg::RAW_MAX;
                end
                if (run_len == 6'd0) begin
                    r.done_res = 1'b1;
                end else begin
                    eng_hdr   = {2'b00, run_len};
                    eng_shift = rq.wdata;
                    eng_count = 7'd0;
                    eng_phase = ST_RAW;
                end
            end
        end

        case (eng_phase)
            ST_IDLE: begin
            end
            ST_HEADER: begin
                r.clk_pulse = 1'b1;
                r.dio_out   = eng_hdr[eng_count[2:0]];
                eng_count   = eng_count + 7'd1;
                if (eng_count >= 7'd8) begin
                    eng_count = 7'd0;
                    eng_phase = ST_TURN_RX;
                end
            end
            ST_TURN_RX: begin
                r.clk_pulse = 1'b1;
                r.dio_drive = 1'b0;
                eng_count   = 7'd0;
                eng_phase   = ST_ACK;
            end
            ST_ACK: begin
                r.clk_pulse = 1'b1;
                r.dio_drive = 1'b0;
                eng_ack     = eng_ack | ({2'b00, rq.dio_in} << eng_count[1:0]);
                eng_count   = eng_count + 7'd1;
                if (eng_count >= 7'd3) begin
                    eng_count = 7'd0;
                    eng_par   = 1'b0;
                    eng_phase = (eng_read && eng_ack == swd_pkg::ACK_OK) ? ST_RD_DATA
                                                                         : ST_TURN_TX;
                end
            end
            ST_RD_DATA: begin
                r.clk_pulse = 1'b1;
                r.dio_drive = 1'b0;
                eng_shift   = {rq.dio_in, eng_shift[31:1]};
                eng_par     = eng_par ^ rq.dio_in;
                eng_count   = eng_count + 7'd1;
                if (eng_count >= 7'd32) begin
                    eng_count = 7'd0;
                    eng_phase = ST_RD_PARITY;
                end
            end
            ST_RD_PARITY: begin
                r.clk_pulse = 1'b1;
                r.dio_drive = 1'b0;
                eng_par     = eng_par ^ rq.dio_in;
                eng_phase   = ST_TURN_TX;
            end
            ST_TURN_TX: begin
                r.clk_pulse = 1'b1;
                if (eng_read) begin
                    // Read ends here, whatever the ACK
                    r.done_res = 1'b1;
                    r.ack_bits = eng_ack;
                    if (eng_ack != swd_pkg::ACK_OK) begin
                        r.status = swd_pkg::STAT_FAULT;
                    end else begin
                        r.status    = eng_par ? swd_pkg::STAT_PARITY : swd_pkg::STAT_OK;
                        r.read_data = eng_shift;
                    end
                    eng_phase = ST_IDLE;
                end else if (eng_ack != swd_pkg::ACK_OK && !eng_skip_ack) begin
                    r.done_res = 1'b1;
                    r.ack_bits = eng_ack;
                    r.status   = swd_pkg::STAT_FAULT;
                    eng_phase  = ST_IDLE;
                end else begin
                    eng_count = 7'd0;
                    eng_par   = 1'b0;
                    eng_phase = ST_WR_DATA;
                end
            end
            ST_WR_DATA: begin
                r.clk_pulse = 1'b1;
                r.dio_out   = eng_shift[0];
                eng_par     = eng_par ^ eng_shift[0];
                eng_shift   = eng_shift >> 1;
                eng_count   = eng_count + 7'd1;
                if (eng_count >= 7'd32) begin
                    eng_count = 7'd0;
                    eng_phase = ST_WR_PARITY;
                end
            end
            ST_WR_PARITY: begin
                r.clk_pulse = 1'b1;
                r.dio_out   = eng_par;
                r.done_res  = 1'b1;
                r.ack_bits  = eng_ack;
                eng_phase   = ST_IDLE;
            end
            ST_LINE_RESET: begin
                r.clk_pulse = 1'b1;
                r.dio_out   = 1'b1;
                eng_count   = eng_count + 7'd1;
                if (eng_count >= 7'(swd_pkg::LINE_RESET_BITS_DEF)) begin
                    eng_count  = 7'd0;
                    r.done_res = 1'b1;
                    eng_phase  = ST_IDLE;
                end
            end
            ST_RAW: begin
                r.clk_pulse = 1'b1;
                r.dio_out   = eng_shift[0];
                eng_shift   = eng_shift >> 1;
                eng_count   = eng_count + 7'd1;
                if ({1'b0, eng_count} >= eng_hdr) begin
                    eng_count  = 7'd0;
                    r.done_res = 1'b1;
                    eng_phase  = ST_IDLE;
                end
            end
            default: begin
                eng_phase = ST_IDLE;
            end
        endcase

        r.busy_res = (eng_phase != ST_IDLE);
        return r;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t: result %0d: %s got 0x%0h, want 0x%0h",
                 $realtime, result_idx, what, got, exp_val);
        o_fail_count = o_fail_count + 1;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Predict on every accepted request item, compare on every result item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            eng_phase    = ST_IDLE;
            eng_count    = 7'd0;
            eng_shift    = 32'd0;
            eng_hdr      = 8'd0;
            eng_par      = 1'b0;
            eng_ack      = 3'd0;
            eng_read     = 1'b0;
            eng_skip_ack = 1'b0;
            expected_q.delete();
            result_idx   = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                seen_req.func       = i_func;
                seen_req.is_ap      = i_is_ap;
                seen_req.reg_addr   = i_reg_addr;
                seen_req.wdata      = i_wdata;
                seen_req.ignore_ack = i_ignore_ack;
                seen_req.raw_count  = i_raw_count;
                seen_req.dio_in     = i_dio_in;
                expected_q.push_back(predict_bit_period(seen_req));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'd0, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_dio_out !== want.dio_out)
                        report_mismatch("dio_out", 32'(i_dio_out), 32'(want.dio_out));
                    if (i_dio_drive !== want.dio_drive)
                        report_mismatch("dio_drive", 32'(i_dio_drive), 32'(want.dio_drive));
                    if (i_clk_pulse !== want.clk_pulse)
                        report_mismatch("clk_pulse", 32'(i_clk_pulse), 32'(want.clk_pulse));
                    if (i_busy_res !== want.busy_res)
                        report_mismatch("busy_res", 32'(i_busy_res), 32'(want.busy_res));
                    if (i_done_res !== want.done_res)
                        report_mismatch("done_res", 32'(i_done_res), 32'(want.done_res));
                    if (i_ack_bits !== want.ack_bits)
                        report_mismatch("ack_bits", 32'(i_ack_bits), 32'(want.ack_bits));
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                    if (i_read_data !== want.read_data)
                        report_mismatch("read_data", i_read_data, want.read_data);
                end
                result_idx = result_idx + 1;
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/tb_swd_host_transaction_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SWD host transaction engine - testbench top
// Drives whole SWD transactions bit period by bit period, with target ACK and
// read data placed on dio_in at the right periods, under several idling and
// back-pressure patterns. The checker beside the engine does all comparison.
// ----------------------------------------------------------------------------
module tb_swd_host_transaction_engine;

    // Target responses other than OK
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;
    localparam logic [2:0] ACK_NONE  = 3'b111;

    // Unused function codes, treated as plain ticks
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    localparam int PHASE_ITEMS     = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int TIMEOUT_NS      = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_func;
    logic        i_is_ap;
    logic [1:0]  i_reg_addr;
    logic [31:0] i_wdata;
    logic        i_ignore_ack;
    logic [5:0]  i_raw_count;
    logic        i_dio_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_dio_out;
    logic        o_dio_drive;
    logic        o_clk_pulse;
    logic        o_busy_res;
    logic        o_done_res;
    logic [2:0]  o_ack_bits;
    logic [1:0]  o_status;
    logic [31:0] o_read_data;

    int          fail_count;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          noise_pct;
    int          items_sent;
    bit          hold_off_req;

    swd_host_transaction_engine u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_is_ap      (i_is_ap),
        .i_reg_addr   (i_reg_addr),
        .i_wdata      (i_wdata),
        .i_ignore_ack (i_ignore_ack),
        .i_raw_count  (i_raw_count),
        .i_dio_in     (i_dio_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dio_out    (o_dio_out),
        .o_dio_drive  (o_dio_drive),
        .o_clk_pulse  (o_clk_pulse),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_ack_bits   (o_ack_bits),
        .o_status     (o_status),
        .o_read_data  (o_read_data)
    );

    swd_host_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_is_ap      (i_is_ap),
        .i_reg_addr   (i_reg_addr),
        .i_wdata      (i_wdata),
        .i_ignore_ack (i_ignore_ack),
        .i_raw_count  (i_raw_count),
        .i_dio_in     (i_dio_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_dio_out    (o_dio_out),
        .i_dio_drive  (o_dio_drive),
        .i_clk_pulse  (o_clk_pulse),
        .i_busy_res   (o_busy_res),
        .i_done_res   (o_done_res),
        .i_ack_bits   (o_ack_bits),
        .i_status     (o_status),
        .i_read_data  (o_read_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Give up after a generous fixed time
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Fully random item: any function code, any field values
    function automatic swd_pkg::t_req random_item();
        swd_pkg::t_req rq;
        rq.func       = 3'($urandom_range(7));
        rq.is_ap      = 1'($urandom_range(1));
        rq.reg_addr   = 2'($urandom_range(3));
        rq.wdata      = $urandom();
        rq.ignore_ack = 1'($urandom_range(1));
        rq.raw_count  = 6'($urandom_range(63));
        rq.dio_in     = 1'($urandom_range(1));
        return rq;
    endfunction

    function automatic swd_pkg::t_req make_req(input logic [2:0] func, input logic is_ap,
                                               input logic [1:0] reg_addr,
                                               input logic [31:0] wdata,
                                               input logic ignore_ack,
                                               input logic [5:0] raw_count);
        swd_pkg::t_req rq;
        rq            = random_item();
        rq.func       = func;
        rq.is_ap      = is_ap;
        rq.reg_addr   = reg_addr;
        rq.wdata      = wdata;
        rq.ignore_ack = ignore_ack;
        rq.raw_count  = raw_count;
        return rq;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input swd_pkg::t_req rq);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= rq.func;
        i_is_ap      <= rq.is_ap;
        i_reg_addr   <= rq.reg_addr;
        i_wdata      <= rq.wdata;
        i_ignore_ack <= rq.ignore_ack;
        i_raw_count  <= rq.raw_count;
        i_dio_in     <= rq.dio_in;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent = items_sent + 1;
    endtask

    // Drop valid and wait until every predicted result item has come
    task automatic wait_for_results(input int max_cycles);
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && n < max_cycles) begin
            @(posedge i_clk);
            n = n + 1;
        end
    endtask

    // Run one request from the idle engine to its completion, playing the
    // target on dio_in: ACK bits LSB first, then read data and its parity
    task automatic run_request(input swd_pkg::t_req start, input logic [2:0] ack_code,
                               input logic [31:0] rd_word, input logic par_flip);
        swd_pkg::t_req rq;
        int            len;
        int            k;
        logic [5:0]    run_len;
        case (start.func)
            swd_pkg::FUNC_READ:   len = (ack_code == swd_pkg::ACK_OK) ? 46 : 13;
            swd_pkg::FUNC_WRITE:  len = (ack_code == swd_pkg::ACK_OK || start.ignore_ack)
                                        ? 46 : 13;
            swd_pkg::FUNC_LRESET: len = int'(swd_pkg::LINE_RESET_BITS_DEF);
            swd_pkg::FUNC_RAW: begin
                run_len = (start.raw_count > swd_pkg::RAW_MAX) ? swd_pkg::RAW_MAX
                                                               : start.raw_count;
                len     = (run_len == 6'd0) ? 1 : int'(run_len);
            end
            default:     len = 1;
        endcase
        send_item(start);
        for (k = 1; k < len; k++) begin
            rq = random_item();
            // Requests while busy must be ignored; keep most periods plain ticks
            if ($urandom_range(99) >= noise_pct) begin
                rq.func = swd_pkg::FUNC_TICK;
            end
            if (start.func == swd_pkg::FUNC_READ || start.func == swd_pkg::FUNC_WRITE) begin
                if (k >= 9 && k <= 11) begin
                    rq.dio_in = ack_code[k - 9];
                end else if (start.func == swd_pkg::FUNC_READ &&
                             ack_code == swd_pkg::ACK_OK) begin
                    if (k >= 12 && k <= 43) begin
                        rq.dio_in = rd_word[k - 12];
                    end else if (k == 44) begin
                        rq.dio_in = (^rd_word) ^ par_flip;
                    end
                end
            end
            send_item(rq);
        end
    endtask

    // Pick a request mix weighted towards full read and write transactions
    task automatic random_request();
        swd_pkg::t_req st;
        logic [2:0]    ack_code;
        logic [2:0]    odd_func;
        int            sel;
        sel      = $urandom_range(99);
        st       = random_item();
        odd_func = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        if (sel < 32) begin
            st.func = swd_pkg::FUNC_READ;
        end else if (sel < 64) begin
            st.func = swd_pkg::FUNC_WRITE;
        end else if (sel < 84) begin
            st.func = swd_pkg::FUNC_RAW;
            if ($urandom_range(3) != 0) begin
                st.raw_count = 6'($urandom_range(12));
            end
        end else if (sel < 88) begin
            st.func = swd_pkg::FUNC_LRESET;
        end else begin
            st.func = ($urandom_range(1) != 0) ? swd_pkg::FUNC_TICK : odd_func;
        end
        ack_code = ($urandom_range(99) < 70) ? swd_pkg::ACK_OK : 3'($urandom_range(7));
        run_request(st, ack_code, $urandom(), ($urandom_range(99) < 15));
    endtask

    // Stimulus
    initial begin
        int phase_idx;
        int phase_start;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_func       <= swd_pkg::FUNC_TICK;
        i_is_ap      <= 1'b0;
        i_reg_addr   <= 2'd0;
        i_wdata      <= 32'd0;
        i_ignore_ack <= 1'b0;
        i_raw_count  <= 6'd0;
        i_dio_in     <= 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        noise_pct    = 10;
        items_sent   = 0;
        hold_off_req = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads with good data, parity wrong both ways, and a WAIT
        run_request(make_req(swd_pkg::FUNC_READ, 1'b0, 2'd0, 32'd0, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'hFFFF_FFFF, 1'b0);
        run_request(make_req(swd_pkg::FUNC_READ, 1'b1, 2'd3, 32'd0, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'h0000_0000, 1'b1);
        run_request(make_req(swd_pkg::FUNC_READ, 1'b1, 2'd1, 32'd0, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'h0000_0001, 1'b1);
        run_request(make_req(swd_pkg::FUNC_READ, 1'b0, 2'd2, 32'd0, 1'b0, 6'd0),
                    ACK_WAIT, 32'd0, 1'b0);
        // Writes: good, faulted, and faulted with the ACK ignored
        run_request(make_req(swd_pkg::FUNC_WRITE, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(swd_pkg::FUNC_WRITE, 1'b0, 2'd0, 32'h0000_0000, 1'b0, 6'd0),
                    ACK_FAULT, 32'd0, 1'b0);
        noise_pct = 100;
        run_request(make_req(swd_pkg::FUNC_WRITE, 1'b0, 2'd1, 32'hA5A5_5A5A, 1'b1, 6'd0),
                    ACK_NONE, 32'd0, 1'b0);
        noise_pct = 10;
        // Line reset, raw runs of zero, full, saturated and single length
        run_request(make_req(swd_pkg::FUNC_LRESET, 1'b0, 2'd0, 32'd0, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(swd_pkg::FUNC_RAW, 1'b0, 2'd0, 32'hFFFF_FFFF, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(swd_pkg::FUNC_RAW, 1'b0, 2'd0, 32'hC33C_9669, 1'b0,
                             swd_pkg::RAW_MAX),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(swd_pkg::FUNC_RAW, 1'b1, 2'd3, 32'h8000_0001, 1'b1, 6'd63),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(swd_pkg::FUNC_RAW, 1'b0, 2'd0, 32'h0000_0001, 1'b0, 6'd1),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        // Tick only and the unused function codes
        run_request(make_req(swd_pkg::FUNC_TICK, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1, 6'd63),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(FUNC_UNUSED_LO, 1'b0, 2'd0, 32'd0, 1'b0, 6'd0),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        run_request(make_req(FUNC_UNUSED_HI, 1'b1, 2'd2, 32'd0, 1'b1, 6'd32),
                    swd_pkg::ACK_OK, 32'd0, 1'b0);
        wait_for_results(DRAIN_LIMIT);

        // Random: no idling, sender idle, receiver stalling, both
        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            case (phase_idx)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            // Hold results off for a long stretch while requests keep coming
            if (phase_idx == 0) begin
                hold_off_req = 1'b1;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                random_request();
            end
            wait_for_results(DRAIN_LIMIT);
        end

        // Drain, let the pipeline settle, then give the verdict
        stall_pct = 0;
        wait_for_results(DRAIN_LIMIT);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/swd_pkg.sv
hdl/swd_engine.sv
hdl/swd_host_transaction_engine.sv
bench/swd_host_checker.sv
bench/tb_swd_host_transaction_engine.sv
